// File: hdl/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared codes, types and pixel packing functions of the format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  localparam logic [1:0] FMT_INDEX8 = 2'd0;
  localparam logic [1:0] FMT_RGB16  = 2'd1;
  localparam logic [1:0] FMT_RGB24  = 2'd2;
  localparam logic [1:0] FMT_ARGB32 = 2'd3;

  localparam logic [1:0] OP_CONVERT = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [0:0] REG_SOURCE_FORMAT = 1'd0;
  localparam logic [0:0] REG_DEST_FORMAT   = 1'd1;

  // how the second stage builds its result
  localparam logic [1:0] KIND_DIRECT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // floor(x / 3) = (x * 683) >> 11 for x below 2048
  localparam logic [9:0] DIV3_RECIP = 10'd683;
  localparam int DIV3_SHIFT = 11;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic              wr_en;
    logic [PAL_AW-1:0] wr_addr;
    rgb_t              wr_data;
    logic              rd_en;
    logic [PAL_AW-1:0] rd_addr;
  } pal_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] pixel;
    rgb_t        colour;
  } stage_t;

  // colour channels of a non-index source pixel
  function automatic rgb_t unpack_source(input logic [1:0] fmt, input logic [31:0] px);
    rgb_t c;
    if (fmt == FMT_RGB16) begin
      c.red   = {px[4:0], 3'b000};
      c.green = {px[10:5], 2'b00};
      c.blue  = {px[15:11], 3'b000};
    end else begin
      c.blue  = px[7:0];
      c.green = px[15:8];
      c.red   = px[23:16];
    end
    return c;
  endfunction

  // non-index destination pixel from a colour
  function automatic logic [31:0] pack_dest(input logic [1:0] fmt, input rgb_t c);
    logic [31:0] p;
    case (fmt)
      FMT_RGB16: p = {16'h0000, c.blue[7:3], c.green[7:2], c.red[7:3]};
      FMT_RGB24: p = {8'h00, c.red, c.green, c.blue};
      default:   p = {ALPHA_OPAQUE, c.red, c.green, c.blue};
    endcase
    return p;
  endfunction

  function automatic logic [31:0] reverse_pixel(input logic [1:0] fmt, input logic [31:0] px);
    logic [31:0] p;
    case (fmt)
      FMT_INDEX8: p = {24'h000000, px[7:0]};
      FMT_RGB16:  p = {16'h0000, px[7:0], px[15:8]};
      FMT_RGB24:  p = {8'h00, px[7:0], px[15:8], px[23:16]};
      default:    p = {px[7:0], px[15:8], px[23:16], px[31:24]};
    endcase
    return p;
  endfunction

  function automatic logic [7:0] grey_index(input rgb_t c);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = {2'b00, c.red} + {2'b00, c.green} + {2'b00, c.blue};
    prod = sum * DIV3_RECIP;
    return prod[DIV3_SHIFT +: 8];
  endfunction

endpackage

// File: hdl/pfc_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_palette
// Palette memory, one write and one registered read per cycle, with a valid
// bit per entry so that unwritten entries read as black after reset.
// ----------------------------------------------------------------------------
module pfc_palette
  import pfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  pal_req_t req,
  input  logic     hold_n,
  output rgb_t     rd_colour
);

  rgb_t                       mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] entry_valid;
  rgb_t                       rd_data;
  logic                       rd_hit;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else begin
      if (req.wr_en) begin
        entry_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit <= entry_valid[req.rd_addr];
      end else if (hold_n) begin
        rd_hit <= 1'b0;
      end
    end
  end

  assign rd_colour = rd_hit ? rd_data : '0;

endmodule

// File: hdl/pfc_issue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_issue
// First stage: decodes a word, issues palette accesses and precomputes
// everything that needs no palette data.
// ----------------------------------------------------------------------------
module pfc_issue
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        advance,
  input  logic [1:0]  op,
  input  logic [31:0] pixel_in,
  input  logic [7:0]  entry_index,
  input  rgb_t        entry_colour,
  input  logic [1:0]  source_format,
  input  logic [1:0]  dest_format,
  output pal_req_t    req,
  output logic        s1_valid,
  output stage_t      s1
);

  logic        is_conv;
  logic        is_wr;
  logic        is_rd;
  logic        same_fmt;
  logic        need_pal;
  logic        to_index;
  logic        emits;
  rgb_t        src_colour;
  logic [7:0]  idx;
  stage_t      s1_next;

  always_comb begin
    is_conv    = (op == OP_CONVERT);
    is_wr      = (op == OP_WRITE);
    is_rd      = (op == OP_READ);
    same_fmt   = (source_format == dest_format);
    need_pal   = is_conv && !same_fmt && (source_format == FMT_INDEX8);
    to_index   = is_conv && !same_fmt && (dest_format == FMT_INDEX8);
    emits      = is_conv || is_rd;
    src_colour = unpack_source(source_format, pixel_in);
    idx        = grey_index(src_colour);

    req.wr_en   = accept && (is_wr || to_index);
    req.wr_addr = is_wr ? entry_index : idx;
    req.wr_data = is_wr ? entry_colour : src_colour;
    req.rd_en   = accept && (need_pal || is_rd);
    req.rd_addr = is_rd ? entry_index : pixel_in[7:0];

    s1_next.colour = '0;
    if (is_rd) begin
      s1_next.kind  = KIND_READ;
      s1_next.pixel = '0;
    end else if (need_pal) begin
      s1_next.kind  = KIND_LOOKUP;
      s1_next.pixel = '0;
    end else if (same_fmt) begin
      s1_next.kind  = KIND_DIRECT;
      s1_next.pixel = reverse_pixel(source_format, pixel_in);
    end else if (to_index) begin
      s1_next.kind   = KIND_DIRECT;
      s1_next.pixel  = {24'h000000, idx};
      s1_next.colour = src_colour;
    end else begin
      s1_next.kind  = KIND_DIRECT;
      s1_next.pixel = pack_dest(dest_format, src_colour);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emits;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

endmodule

// File: hdl/pfc_output.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_output
// Second stage: merges palette read data into the result and holds it in
// the output register until the sink takes it.
// ----------------------------------------------------------------------------
module pfc_output
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s1_valid,
  input  stage_t      s1,
  input  rgb_t        pal_colour,
  input  logic [1:0]  dest_format,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [55:0] m_tdata,
  output logic        out_free
);

  logic [31:0] pixel;
  rgb_t        colour;

  always_comb begin
    case (s1.kind)
      KIND_READ: begin
        pixel  = '0;
        colour = pal_colour;
      end
      KIND_LOOKUP: begin
        pixel  = pack_dest(dest_format, pal_colour);
        colour = '0;
      end
      default: begin
        pixel  = s1.pixel;
        colour = s1.colour;
      end
    endcase
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      m_tdata <= {colour.blue, colour.green, colour.red, pixel};
    end
  end

endmodule

// File: hdl/pixel_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_converter
// Pixel conversion between index8, rgb16, rgb24 and argb32 with a palette.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_*       in         op (tuser), pixel, entry index, entry colour
// m_*       out        converted pixel and palette colour
// cfg_*     in         source_format (index 0), dest_format (index 1)
//
// one word per clock sustained while the sink takes results; a result passes
// through a stage for the palette read and then the output register.
// palette writes and lookups use one write and one read port of the palette
// memory; per-entry valid bits make it read as black right after reset.
// a stalled sink holds the second stage, and s_tready drops only then.
// ----------------------------------------------------------------------------
module pixel_format_converter
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pixel_in, entry_index, entry_red, entry_green, entry_blue
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // pixel_out, colour_red, colour_green, colour_blue
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  logic [1:0] source_format;
  logic [1:0] dest_format;
  logic       accept;
  logic       advance;
  logic       out_free;
  logic       s1_valid;
  stage_t     s1;
  pal_req_t   req;
  rgb_t       pal_colour;
  rgb_t       entry_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_ARGB32;
      dest_format   <= FMT_ARGB32;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_FORMAT: source_format <= cfg_data;
        REG_DEST_FORMAT:   dest_format   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !s1_valid || out_free;
  assign accept   = s_tvalid && s_tready;
  assign advance  = s1_valid && out_free;

  assign entry_colour.red   = s_tdata[47:40];
  assign entry_colour.green = s_tdata[55:48];
  assign entry_colour.blue  = s_tdata[63:56];

  pfc_issue u_issue (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .advance       (advance),
    .op            (s_tuser),
    .pixel_in      (s_tdata[31:0]),
    .entry_index   (s_tdata[39:32]),
    .entry_colour  (entry_colour),
    .source_format (source_format),
    .dest_format   (dest_format),
    .req           (req),
    .s1_valid      (s1_valid),
    .s1            (s1)
  );

  pfc_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .hold_n    (advance),
    .rd_colour (pal_colour)
  );

  pfc_output u_output (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1          (s1),
    .pal_colour  (pal_colour),
    .dest_format (dest_format),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .out_free    (out_free)
  );

endmodule

// File: hdl/pfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker
  import pfc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an empty output register never blocks the source
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("source stalled with empty output");

  // a new result comes from an accepted convert or read word
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |->
      $past(s_tvalid && s_tready && (s_tuser == OP_CONVERT || s_tuser == OP_READ), 2))
    else $error("result without a matching word");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
